// ===== sv/lch_pkg.sv =====
`timescale 1ns / 1ps
package lch_pkg;

  localparam int MAX_DIMS      = 3;
  localparam int MAX_INSTANCES = 64;
  localparam int BUCKET_COUNT  = 10;
  localparam int FINITE_BOUNDS = 9;
  localparam int SLOT_COUNT    = MAX_INSTANCES + 1;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);
  localparam int CNT_W         = 64;
  localparam int ROW_W         = (BUCKET_COUNT + 2) * CNT_W;

  localparam logic [1:0] KIND_OBS_LABELED  = 2'd0;
  localparam logic [1:0] KIND_OBS_BASE     = 2'd1;
  localparam logic [1:0] KIND_READ_LABELED = 2'd2;
  localparam logic [1:0] KIND_READ_BASE    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LABEL = 2'd1;
  localparam logic [1:0] ST_OVER_CAP  = 2'd2;

  localparam logic [1:0] CFG_DIMS  = 2'd0;
  localparam logic [1:0] CFG_SIZE0 = 2'd1;
  localparam logic [1:0] CFG_SIZE1 = 2'd2;
  localparam logic [1:0] CFG_SIZE2 = 2'd3;

  // Bucket bounds in Q24.24, rounded to nearest.
  localparam logic signed [47:0] BOUND_Q24 [FINITE_BOUNDS] = '{
    48'sd16777, 48'sd83886, 48'sd167772, 48'sd838861, 48'sd1677722,
    48'sd8388608, 48'sd16777216, 48'sd83886080, 48'sd167772160
  };

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         labels_given;
    logic [5:0]         ordinal0;
    logic [5:0]         ordinal1;
    logic [5:0]         ordinal2;
    logic signed [47:0] sample_value;
    logic [3:0]         bucket_select;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        bucket_count;
    logic [63:0]        total_count;
    logic signed [63:0] value_sum;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

endpackage

// ===== sv/labeled_cumulative_histogram_core.sv =====
`timescale 1ns / 1ps
// Each accepted word passes the slot lookup state and then the read-modify-write
// state on the single row-wide instance memory before its result strobe; busy
// covers both states, so no new word is accepted until the last is through.
// The receiver cannot stall; each result strobe lasts exactly one cycle.
// Reset (synchronous, rst_n low) restores the configuration and marks all 65
// memory rows invalid, so every counter reads as zero at once; no clearing pass.
module labeled_cumulative_histogram_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lch_pkg::in_word_t    in_data,
  output logic                 out_strobe,
  output lch_pkg::out_word_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [6:0]           cfg_data
);

  lch_pkg::state_t state_r, state_nxt;

  logic [1:0] dims_r;
  logic [6:0] size0_r, size1_r, size2_r;

  lch_pkg::in_word_t item_r;
  logic [1:0]                   status_r;
  logic [lch_pkg::SLOT_W-1:0]   slot_r;

  logic [lch_pkg::ROW_W-1:0]    mem [lch_pkg::SLOT_COUNT];
  logic [lch_pkg::ROW_W-1:0]    rd_row_r;
  logic [lch_pkg::SLOT_COUNT-1:0] row_valid_r;
  logic                         rd_valid_r;

  logic                         out_strobe_r;
  lch_pkg::out_word_t           out_r;

  logic accept, do_lookup, do_update;

  assign cfg_ready  = 1'b1;
  assign busy       = (state_r != lch_pkg::S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;
  assign accept     = start && !busy;

  always_comb begin
    state_nxt = state_r;
    do_lookup = 1'b0;
    do_update = 1'b0;
    case (state_r)
      lch_pkg::S_IDLE: begin
        if (accept) state_nxt = lch_pkg::S_LOOKUP;
      end
      lch_pkg::S_LOOKUP: begin
        do_lookup = 1'b1;
        state_nxt = lch_pkg::S_UPDATE;
      end
      lch_pkg::S_UPDATE: begin
        do_update = 1'b1;
        state_nxt = lch_pkg::S_IDLE;
      end
      default: state_nxt = lch_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lch_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r  <= 2'd0;
      size0_r <= 7'd1;
      size1_r <= 7'd1;
      size2_r <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lch_pkg::CFG_DIMS:  dims_r  <= cfg_data[1:0];
        lch_pkg::CFG_SIZE0: size0_r <= cfg_data;
        lch_pkg::CFG_SIZE1: size1_r <= cfg_data;
        lch_pkg::CFG_SIZE2: size2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
  end

  // Slot lookup. Unused dimensions act as size one with ordinal zero.
  logic [6:0]  e0, e1, e2;
  logic [5:0]  o0, o1, o2;
  logic [20:0] cap;
  logic [20:0] flat;
  logic        over_cap, bad_label, is_base;
  logic [1:0]  status_c;
  logic [lch_pkg::SLOT_W-1:0] slot_c;

  always_comb begin
    e0 = (dims_r > 2'd0) ? size0_r : 7'd1;
    e1 = (dims_r > 2'd1) ? size1_r : 7'd1;
    e2 = (dims_r > 2'd2) ? size2_r : 7'd1;
    o0 = (dims_r > 2'd0) ? item_r.ordinal0 : 6'd0;
    o1 = (dims_r > 2'd1) ? item_r.ordinal1 : 6'd0;
    o2 = (dims_r > 2'd2) ? item_r.ordinal2 : 6'd0;
    cap  = 21'(14'(e0 * e1) * e2);
    flat = 21'(14'(o0 * e1 + 14'(o1)) * e2 + 21'(o2));
    over_cap  = (e0 == 7'd0) || (e1 == 7'd0) || (e2 == 7'd0) ||
                (cap > 21'(lch_pkg::MAX_INSTANCES));
    bad_label = (item_r.labels_given != dims_r) ||
                ({1'b0, o0} >= e0) || ({1'b0, o1} >= e1) || ({1'b0, o2} >= e2);
    is_base   = (item_r.kind == lch_pkg::KIND_OBS_BASE) ||
                (item_r.kind == lch_pkg::KIND_READ_BASE);
    if (over_cap) begin
      status_c = lch_pkg::ST_OVER_CAP;
      slot_c   = '0;
    end else if (is_base) begin
      status_c = lch_pkg::ST_OK;
      slot_c   = (dims_r != 2'd0) ? lch_pkg::SLOT_W'(cap) : '0;
    end else if (bad_label) begin
      status_c = lch_pkg::ST_BAD_LABEL;
      slot_c   = '0;
    end else begin
      status_c = lch_pkg::ST_OK;
      slot_c   = lch_pkg::SLOT_W'(flat);
    end
  end

  always_ff @(posedge clk) begin
    if (do_lookup) begin
      status_r   <= status_c;
      slot_r     <= slot_c;
      rd_row_r   <= mem[slot_c];
      rd_valid_r <= row_valid_r[slot_c];
    end
  end

  // Read-modify-write of one row: bucket counters, event count, value sum.
  logic [lch_pkg::ROW_W-1:0] cur_row, new_row;
  logic [63:0]        cur_cnt, sel_bucket;
  logic signed [63:0] cur_sum, add_v, raw_sum, sat_sum;
  logic               is_obs, write_en;

  always_comb begin
    cur_row = rd_valid_r ? rd_row_r : '0;
    cur_cnt = cur_row[lch_pkg::BUCKET_COUNT*64 +: 64];
    cur_sum = cur_row[(lch_pkg::BUCKET_COUNT+1)*64 +: 64];
    add_v   = 64'(item_r.sample_value);
    raw_sum = cur_sum + add_v;
    if (cur_sum[63] == add_v[63] && raw_sum[63] != add_v[63])
      sat_sum = add_v[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      sat_sum = raw_sum;
    new_row = cur_row;
    for (int b = 0; b < lch_pkg::BUCKET_COUNT; b++) begin
      if (b >= lch_pkg::FINITE_BOUNDS ||
          item_r.sample_value <= lch_pkg::BOUND_Q24[b % lch_pkg::FINITE_BOUNDS])
        new_row[b*64 +: 64] = cur_row[b*64 +: 64] + 64'd1;
    end
    new_row[lch_pkg::BUCKET_COUNT*64 +: 64]     = cur_cnt + 64'd1;
    new_row[(lch_pkg::BUCKET_COUNT+1)*64 +: 64] = sat_sum;
    sel_bucket = '0;
    for (int b = 0; b < lch_pkg::BUCKET_COUNT; b++) begin
      if (item_r.bucket_select == 4'(b)) sel_bucket = cur_row[b*64 +: 64];
    end
    is_obs   = (item_r.kind == lch_pkg::KIND_OBS_LABELED) ||
               (item_r.kind == lch_pkg::KIND_OBS_BASE);
    write_en = do_update && is_obs && (status_r == lch_pkg::ST_OK);
  end

  always_ff @(posedge clk) begin
    if (write_en) mem[slot_r] <= new_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) row_valid_r <= '0;
    else if (write_en) row_valid_r[slot_r] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= do_update;
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      out_r.status <= status_r;
      if (!is_obs && status_r == lch_pkg::ST_OK) begin
        out_r.bucket_count <= sel_bucket;
        out_r.total_count  <= cur_cnt;
        out_r.value_sum    <= cur_sum;
      end else begin
        out_r.bucket_count <= '0;
        out_r.total_count  <= '0;
        out_r.value_sum    <= '0;
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  lch_pkg::in_word_t  in_data = '0;
  logic      out_strobe;
  lch_pkg::out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  labeled_cumulative_histogram_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the histogram table and its configuration.
  logic [63:0]        bucket_tbl [lch_pkg::SLOT_COUNT][lch_pkg::BUCKET_COUNT];
  logic [63:0]        event_tbl [lch_pkg::SLOT_COUNT];
  logic signed [63:0] sum_tbl [lch_pkg::SLOT_COUNT];
  logic [1:0]         dims_cfg;
  logic [6:0]         size_cfg [3];

  lch_pkg::out_word_t expected_results [$];
  int  error_count = 0;
  int  idle_pct = 0;
  int  quiet_cycles = 0;
  int  results_seen = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
             results_seen);
    error_count++;
  endtask

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] wide;
    wide = {a[63], a} + {b[63], b};
    if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (wide < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return wide[63:0];
  endfunction

  // Works out the result of one word and updates the shadow table.
  function automatic lch_pkg::out_word_t histogram_result(input lch_pkg::in_word_t w);
    lch_pkg::out_word_t r;
    int cap, flat, slot;
    logic [6:0] ords [3];
    logic signed [63:0] s;
    r = '0;
    cap = 1;
    ords[0] = {1'b0, w.ordinal0}; ords[1] = {1'b0, w.ordinal1};
    ords[2] = {1'b0, w.ordinal2};
    for (int d = 0; d < dims_cfg; d++) begin
      if (size_cfg[d] == 0) cap = lch_pkg::MAX_INSTANCES + 1;
      else cap = cap * size_cfg[d];
    end
    if (cap > lch_pkg::MAX_INSTANCES) begin
      r.status = lch_pkg::ST_OVER_CAP;
      return r;
    end
    if (w.kind == lch_pkg::KIND_OBS_BASE || w.kind == lch_pkg::KIND_READ_BASE) begin
      slot = (dims_cfg > 0) ? cap : 0;
    end else begin
      if (w.labels_given != dims_cfg) begin
        r.status = lch_pkg::ST_BAD_LABEL;
        return r;
      end
      flat = 0;
      for (int d = 0; d < dims_cfg; d++) begin
        if (ords[d] >= size_cfg[d]) begin
          r.status = lch_pkg::ST_BAD_LABEL;
          return r;
        end
        flat = flat * size_cfg[d] + ords[d];
      end
      slot = flat;
    end
    r.status = lch_pkg::ST_OK;
    if (w.kind == lch_pkg::KIND_OBS_LABELED || w.kind == lch_pkg::KIND_OBS_BASE) begin
      s = 64'(w.sample_value);
      event_tbl[slot] += 64'd1;
      sum_tbl[slot] = sat_sum(sum_tbl[slot], s);
      for (int b = 0; b < lch_pkg::BUCKET_COUNT; b++)
        if (b >= lch_pkg::FINITE_BOUNDS || s <= 64'(lch_pkg::BOUND_Q24[b]))
          bucket_tbl[slot][b] += 64'd1;
    end else begin
      if (w.bucket_select < lch_pkg::BUCKET_COUNT)
        r.bucket_count = bucket_tbl[slot][w.bucket_select];
      r.total_count = event_tbl[slot];
      r.value_sum = sum_tbl[slot];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    lch_pkg::out_word_t e;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data.status), 64'd0);
      end else begin
        e = expected_results.pop_front();
        if (out_data.status !== e.status)
          report_mismatch("status", 64'(out_data.status), 64'(e.status));
        if (out_data.bucket_count !== e.bucket_count)
          report_mismatch("bucket_count", out_data.bucket_count, e.bucket_count);
        if (out_data.total_count !== e.total_count)
          report_mismatch("total_count", out_data.total_count, e.total_count);
        if (out_data.value_sum !== e.value_sum)
          report_mismatch("value_sum", out_data.value_sum, e.value_sum);
      end
    end
  end

  // Watchdog on cycles with no accepted word, result strobe or configuration write.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Start stays high after an accept until the next idle cycle or a drain.
  task automatic send_word(input lch_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    expected_results.push_back(histogram_result(w));
  endtask

  task automatic wait_drained;
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lch_pkg::CFG_DIMS:  dims_cfg = val[1:0];
      lch_pkg::CFG_SIZE0: size_cfg[0] = val;
      lch_pkg::CFG_SIZE1: size_cfg[1] = val;
      default:            size_cfg[2] = val;
    endcase
  endtask

  task automatic set_shape(input int dims, input int s0, input int s1, input int s2);
    wait_drained();
    write_reg(lch_pkg::CFG_DIMS, 2'(dims));
    write_reg(lch_pkg::CFG_SIZE0, 7'(s0));
    write_reg(lch_pkg::CFG_SIZE1, 7'(s1));
    write_reg(lch_pkg::CFG_SIZE2, 7'(s2));
    cfg_valid <= 1'b0;
  endtask

  function automatic lch_pkg::in_word_t make_word(input logic [1:0] kind, input int o0,
                                                  input int o1, input int o2,
                                                  input logic [47:0] v, input int sel);
    lch_pkg::in_word_t w;
    w.kind = kind;
    w.labels_given = dims_cfg;
    w.ordinal0 = 6'(o0); w.ordinal1 = 6'(o1); w.ordinal2 = 6'(o2);
    w.sample_value = v;
    w.bucket_select = 4'(sel);
    return w;
  endfunction

  // Sample drawn near the bucket bounds half of the time.
  function automatic logic [47:0] pick_sample;
    int k;
    k = $urandom_range(9);
    if (k < 5)
      return 48'(lch_pkg::BOUND_Q24[$urandom_range(lch_pkg::FINITE_BOUNDS - 1)]) +
             48'($urandom_range(2)) - 48'd1;
    if (k == 5) return 48'h7FFF_FFFF_FFFF;
    if (k == 6) return 48'h8000_0000_0000;
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic test_directed;
    lch_pkg::in_word_t w;
    set_shape(0, 1, 1, 1);
    send_word(make_word(lch_pkg::KIND_OBS_LABELED, 0, 0, 0, 48'd0, 0));
    send_word(make_word(lch_pkg::KIND_OBS_BASE, 0, 0, 0, 48'd16777, 0));
    send_word(make_word(lch_pkg::KIND_READ_LABELED, 0, 0, 0, 48'd0, 0));
    send_word(make_word(lch_pkg::KIND_READ_BASE, 0, 0, 0, 48'd0, 15));
    set_shape(3, 4, 4, 4);
    send_word(make_word(lch_pkg::KIND_OBS_LABELED, 3, 3, 3, 48'h7FFF_FFFF_FFFF, 0));
    send_word(make_word(lch_pkg::KIND_OBS_LABELED, 3, 3, 3, 48'h7FFF_FFFF_FFFF, 0));
    send_word(make_word(lch_pkg::KIND_OBS_BASE, 0, 0, 0, 48'h8000_0000_0000, 0));
    send_word(make_word(lch_pkg::KIND_READ_LABELED, 3, 3, 3, 48'd0, 9));
    send_word(make_word(lch_pkg::KIND_READ_BASE, 63, 63, 63, 48'd0, 0));
    send_word(make_word(lch_pkg::KIND_READ_LABELED, 4, 0, 0, 48'd0, 0));
    send_word(make_word(lch_pkg::KIND_OBS_LABELED, 0, 0, 63, 48'd0, 0));
    w = make_word(lch_pkg::KIND_OBS_LABELED, 0, 0, 0, 48'd5, 0);
    w.labels_given = 2'd1;
    send_word(w);
    set_shape(3, 64, 2, 1);
    send_word(make_word(lch_pkg::KIND_OBS_BASE, 0, 0, 0, 48'd1, 0));
    set_shape(1, 0, 1, 1);
    send_word(make_word(lch_pkg::KIND_READ_BASE, 0, 0, 0, 48'd0, 0));
    set_shape(1, 64, 64, 64);
    send_word(make_word(lch_pkg::KIND_OBS_LABELED, 63, 0, 0, 48'd167772160, 0));
    send_word(make_word(lch_pkg::KIND_READ_LABELED, 63, 0, 0, 48'd0, 8));
    send_word(make_word(lch_pkg::KIND_READ_BASE, 0, 0, 0, 48'd0, 12));
  endtask

  task automatic test_random(input int count);
    lch_pkg::in_word_t w;
    for (int i = 0; i < count; i++) begin
      if (i % 120 == 0) begin
        case ($urandom_range(5))
          0: set_shape(0, $urandom_range(1, 64), 1, 1);
          1: set_shape(1, $urandom_range(1, 64), $urandom_range(127), $urandom_range(127));
          2: set_shape(2, $urandom_range(1, 8), $urandom_range(1, 8), 1);
          3: set_shape(3, $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4));
          4: set_shape(3, 2, 2, 2);
          default: set_shape($urandom_range(3), $urandom_range(127), $urandom_range(127),
                             $urandom_range(127));
        endcase
      end
      w = make_word(2'($urandom_range(3)),
                    $urandom_range(size_cfg[0] > 0 ? size_cfg[0] - 1 : 0),
                    $urandom_range(size_cfg[1] > 0 ? size_cfg[1] - 1 : 0),
                    $urandom_range(size_cfg[2] > 0 ? size_cfg[2] - 1 : 0),
                    pick_sample(), $urandom_range(9));
      // Now and then a broken word: any label count, any ordinal, any bucket.
      if ($urandom_range(9) == 0) begin
        w.labels_given = 2'($urandom);
        w.ordinal0 = 6'($urandom); w.ordinal1 = 6'($urandom); w.ordinal2 = 6'($urandom);
        w.bucket_select = 4'($urandom);
      end
      send_word(w);
      if (i == count / 2) wait_drained();
    end
  endtask

  initial begin
    dims_cfg = '0;
    size_cfg = '{7'd1, 7'd1, 7'd1};
    for (int s = 0; s < lch_pkg::SLOT_COUNT; s++) begin
      event_tbl[s] = '0;
      sum_tbl[s] = '0;
      for (int b = 0; b < lch_pkg::BUCKET_COUNT; b++) bucket_tbl[s][b] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    idle_pct = 26;
    test_random(320);
    idle_pct = 62;
    test_random(320);
    idle_pct = 0;
    test_random(320);
    wait_drained();
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
